// ----- design/two_level_priority_core_allocator_macros.svh -----
// assertion macros shared by the allocator checker
`ifndef TWO_LEVEL_PRIORITY_CORE_ALLOCATOR_MACROS_SVH
`define TWO_LEVEL_PRIORITY_CORE_ALLOCATOR_MACROS_SVH

// generic clocked assertion with async active-low reset
`define TLPCA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("allocator check failed");

// assertion on the default clock and reset of the allocator
`define TLPCA_CHECK(lbl, prop) `TLPCA_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ----- design/tlpca_pkg.sv -----
// shared constants, codes and types of the two-level priority core allocator
package tlpca_pkg;

  localparam int CORES       = 2;
  localparam int POOL        = 16;
  localparam int CORE_W      = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int TICKET_W    = $clog2(POOL);
  localparam int COUNT_W     = $clog2(POOL + 1);
  localparam int CFG_CORES_W = 2;
  localparam int CFG_DATA_W  = 2;
  localparam int OPCODE_W    = 2;
  localparam int PRIO_W      = 2;
  localparam int CORE_IDX_W  = 2;
  localparam int STATUS_W    = 4;

  // register indexes
  localparam logic REG_CORES_IN_USE = 1'b0;
  localparam logic REG_HW_ERROR     = 1'b1;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_RESERVE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL  = 2'd2;

  // priorities
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_CANCELLED    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIORITY = 4'd4;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_CORE     = 4'd6;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 4'd7;
  localparam logic [STATUS_W-1:0] ST_HW_ERROR     = 4'd8;
  localparam logic [STATUS_W-1:0] ST_BAD_TICKET   = 4'd9;

  // which waiter a queue search looks for
  typedef enum logic [1:0] {
    SEL_HIGH,
    SEL_LOW,
    SEL_TICKET
  } sel_e;

  // one waiter slot
  typedef struct packed {
    logic                valid;
    logic                is_low;
    logic [TICKET_W-1:0] ticket;
  } entry_t;

  // search state passed from a cell to its right neighbor
  typedef struct packed {
    logic                prev_valid;
    logic                found;
    logic                pick_low;
    logic [TICKET_W-1:0] pick_ticket;
  } link_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                drop_en;
    logic                append_en;
    sel_e                sel;
    logic [TICKET_W-1:0] ticket;
    logic                append_low;
    logic [TICKET_W-1:0] append_ticket;
  } cmd_t;

endpackage

// ----- design/tlpca_cell.sv -----
// one waiter slot of the arrival-ordered queue
module tlpca_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlpca_pkg::cmd_t   cmd_i,
  input  tlpca_pkg::link_t  link_i,
  input  tlpca_pkg::entry_t right_i,
  output tlpca_pkg::link_t  link_o,
  output tlpca_pkg::entry_t entry_o
);

  logic                           valid_q, valid_d;
  logic                           is_low_q, is_low_d;
  logic [tlpca_pkg::TICKET_W-1:0] ticket_q, ticket_d;
  logic                           match;
  logic                           hit;

  always_comb begin
    case (cmd_i.sel)
      tlpca_pkg::SEL_HIGH:   match = !is_low_q;
      tlpca_pkg::SEL_LOW:    match = is_low_q;
      tlpca_pkg::SEL_TICKET: match = (ticket_q == cmd_i.ticket);
      default:               match = 1'b0;
    endcase
    // first matching waiter only
    hit = match && valid_q && !link_i.found;
  end

  assign link_o.prev_valid  = valid_q;
  assign link_o.found       = link_i.found | hit;
  assign link_o.pick_low    = hit ? is_low_q : link_i.pick_low;
  assign link_o.pick_ticket = hit ? ticket_q : link_i.pick_ticket;

  assign entry_o.valid  = valid_q;
  assign entry_o.is_low = is_low_q;
  assign entry_o.ticket = ticket_q;

  always_comb begin
    valid_d  = valid_q;
    is_low_d = is_low_q;
    ticket_d = ticket_q;
    if (cmd_i.drop_en && link_o.found) begin
      // removed slot or one behind it: take the neighbor's waiter
      valid_d  = right_i.valid;
      is_low_d = right_i.is_low;
      ticket_d = right_i.ticket;
    end else if (cmd_i.append_en && !valid_q && link_i.prev_valid) begin
      valid_d  = 1'b1;
      is_low_d = cmd_i.append_low;
      ticket_d = cmd_i.append_ticket;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_low_q <= is_low_d;
    ticket_q <= ticket_d;
  end

endmodule

// ----- design/two_level_priority_core_allocator.sv -----
// top level of the two-level strict-priority core allocator
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------------
//  command   start / busy         opcode_i priority_req_i core_index_i
//                                 cancel_ticket_i
//  result    done_o (one cycle)   status_o granted_core_o ticket_o
//                                 handoff_valid_o handoff_ticket_o
//                                 handoff_core_o busy_mask_o high_waiting_o
//                                 low_waiting_o
//  config    cfg_we_i             cfg_index_i cfg_data_i
//
// for each item the accept edge latches the command; while busy is high the search
// runs through the queue cells, and the edge that ends busy updates all state
// the result shows on the ports in the cycle after that, with done_o high,
// and a new item may be accepted at the end of that same cycle
// the search is a single combinational ripple pass along the cell row
// reset is asynchronous; the queue valid bits, the ticket pool and the core
// busy bits clear at once, so no clearing pass is needed
// the receiver cannot stall; each result is shown for exactly one cycle
module two_level_priority_core_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command
  input  logic                              start,
  output logic                              busy,
  input  logic [tlpca_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [tlpca_pkg::PRIO_W-1:0]      priority_req_i,
  input  logic [tlpca_pkg::CORE_IDX_W-1:0]  core_index_i,
  input  logic [tlpca_pkg::TICKET_W-1:0]    cancel_ticket_i,
  // result
  output logic                              done_o,
  output logic [tlpca_pkg::STATUS_W-1:0]    status_o,
  output logic [tlpca_pkg::CORE_W-1:0]      granted_core_o,
  output logic [tlpca_pkg::TICKET_W-1:0]    ticket_o,
  output logic                              handoff_valid_o,
  output logic [tlpca_pkg::TICKET_W-1:0]    handoff_ticket_o,
  output logic [tlpca_pkg::CORE_W-1:0]      handoff_core_o,
  output logic [tlpca_pkg::CORES-1:0]       busy_mask_o,
  output logic [tlpca_pkg::COUNT_W-1:0]     high_waiting_o,
  output logic [tlpca_pkg::COUNT_W-1:0]     low_waiting_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [tlpca_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // control and configuration
  logic                                busy_q;
  logic                                done_q;
  logic [tlpca_pkg::CFG_CORES_W-1:0]   cores_in_use_q;
  logic                                hw_error_q;

  // latched command
  logic [tlpca_pkg::OPCODE_W-1:0]      op_q;
  logic [tlpca_pkg::PRIO_W-1:0]        prio_q;
  logic [tlpca_pkg::CORE_IDX_W-1:0]    core_q;
  logic [tlpca_pkg::TICKET_W-1:0]      cticket_q;

  // allocator state
  logic [tlpca_pkg::CORES-1:0]         core_busy_q, core_busy_d;
  logic [tlpca_pkg::POOL-1:0]          ticket_in_use_q, ticket_in_use_d;
  logic [tlpca_pkg::COUNT_W-1:0]       high_count_q, high_count_d;
  logic [tlpca_pkg::COUNT_W-1:0]       low_count_q, low_count_d;

  // result registers
  logic [tlpca_pkg::STATUS_W-1:0]      status_q, status_d;
  logic [tlpca_pkg::CORE_W-1:0]        gcore_q, gcore_d;
  logic [tlpca_pkg::TICKET_W-1:0]      ticket_q, ticket_d;
  logic                                hv_q, hv_d;
  logic [tlpca_pkg::TICKET_W-1:0]      ht_q, ht_d;
  logic [tlpca_pkg::CORE_W-1:0]        hc_q, hc_d;

  // search helpers
  logic [tlpca_pkg::CFG_CORES_W-1:0]   n_eff;
  logic                                idle_found;
  logic [tlpca_pkg::CORE_W-1:0]        idle_core;
  logic                                free_found;
  logic [tlpca_pkg::TICKET_W-1:0]      free_ticket;
  logic [tlpca_pkg::CORE_W-1:0]        rel_core;
  logic                                accept;

  // queue cell row
  tlpca_pkg::cmd_t                     cmd;
  tlpca_pkg::link_t                    link_w  [tlpca_pkg::POOL+1];
  tlpca_pkg::entry_t                   entry_w [tlpca_pkg::POOL];
  tlpca_pkg::entry_t                   right_w [tlpca_pkg::POOL];
  tlpca_pkg::link_t                    chain_end;

  assign accept   = start && !busy_q;
  assign busy     = busy_q;
  assign rel_core = core_q[tlpca_pkg::CORE_W-1:0];

  // cores_in_use above the core count acts as the core count
  assign n_eff = (cores_in_use_q > tlpca_pkg::CFG_CORES_W'(tlpca_pkg::CORES)) ?
                 tlpca_pkg::CFG_CORES_W'(tlpca_pkg::CORES) : cores_in_use_q;

  // lowest idle core among the enabled ones
  always_comb begin
    idle_found = 1'b0;
    idle_core  = '0;
    for (int i = 0; i < tlpca_pkg::CORES; i++) begin
      if (!idle_found && !core_busy_q[i] &&
          (tlpca_pkg::CFG_CORES_W'(i) < n_eff)) begin
        idle_found = 1'b1;
        idle_core  = tlpca_pkg::CORE_W'(i);
      end
    end
  end

  // lowest free ticket of the pool
  always_comb begin
    free_found  = 1'b0;
    free_ticket = '0;
    for (int i = 0; i < tlpca_pkg::POOL; i++) begin
      if (!free_found && !ticket_in_use_q[i]) begin
        free_found  = 1'b1;
        free_ticket = tlpca_pkg::TICKET_W'(i);
      end
    end
  end

  // head of the chain: an imaginary valid slot in front of cell zero
  assign link_w[0].prev_valid  = 1'b1;
  assign link_w[0].found       = 1'b0;
  assign link_w[0].pick_low    = 1'b0;
  assign link_w[0].pick_ticket = '0;

  for (genvar g = 0; g < tlpca_pkg::POOL; g++) begin : g_cell
    if (g < tlpca_pkg::POOL - 1) begin : g_mid
      assign right_w[g] = entry_w[g+1];
    end else begin : g_last
      assign right_w[g] = '0;
    end

    tlpca_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .link_i  (link_w[g]),
      .right_i (right_w[g]),
      .link_o  (link_w[g+1]),
      .entry_o (entry_w[g])
    );
  end

  assign chain_end = link_w[tlpca_pkg::POOL];

  // execute step: runs in the cycle after accept
  always_comb begin
    core_busy_d     = core_busy_q;
    ticket_in_use_d = ticket_in_use_q;
    high_count_d    = high_count_q;
    low_count_d     = low_count_q;
    status_d        = tlpca_pkg::ST_BAD_TICKET;
    gcore_d         = '0;
    ticket_d        = '0;
    hv_d            = 1'b0;
    ht_d            = '0;
    hc_d            = '0;

    cmd.drop_en       = 1'b0;
    cmd.append_en     = 1'b0;
    cmd.sel           = tlpca_pkg::SEL_TICKET;
    cmd.ticket        = cticket_q;
    cmd.append_low    = (prio_q == tlpca_pkg::PRIO_LOW);
    cmd.append_ticket = free_ticket;

    if (busy_q) begin
      unique case (op_q)
        tlpca_pkg::OP_RESERVE: begin
          if (hw_error_q) begin
            status_d = tlpca_pkg::ST_HW_ERROR;
          end else if (prio_q != tlpca_pkg::PRIO_HIGH && prio_q != tlpca_pkg::PRIO_LOW) begin
            status_d = tlpca_pkg::ST_BAD_PRIORITY;
          end else if (idle_found) begin
            status_d               = tlpca_pkg::ST_GRANTED;
            gcore_d                = idle_core;
            core_busy_d[idle_core] = 1'b1;
          end else if (free_found) begin
            // a free ticket implies a free queue slot behind the last waiter
            status_d                     = tlpca_pkg::ST_QUEUED;
            ticket_d                     = free_ticket;
            ticket_in_use_d[free_ticket] = 1'b1;
            cmd.append_en                = 1'b1;
            if (prio_q == tlpca_pkg::PRIO_LOW) begin
              low_count_d = low_count_q + tlpca_pkg::COUNT_W'(1);
            end else begin
              high_count_d = high_count_q + tlpca_pkg::COUNT_W'(1);
            end
          end else begin
            status_d = tlpca_pkg::ST_POOL_FULL;
          end
        end
        tlpca_pkg::OP_RELEASE: begin
          if (core_q >= n_eff) begin
            status_d = tlpca_pkg::ST_BAD_CORE;
          end else if (!core_busy_q[rel_core]) begin
            status_d = tlpca_pkg::ST_ALREADY_FREE;
          end else begin
            status_d    = tlpca_pkg::ST_RELEASED;
            cmd.drop_en = 1'b1;
            // strict priority: high waiters first
            cmd.sel     = (high_count_q != '0) ? tlpca_pkg::SEL_HIGH : tlpca_pkg::SEL_LOW;
            if (chain_end.found) begin
              // core goes straight to the oldest waiter of that class and stays reserved
              hv_d = 1'b1;
              ht_d = chain_end.pick_ticket;
              hc_d = rel_core;
              ticket_in_use_d[chain_end.pick_ticket] = 1'b0;
              if (chain_end.pick_low) begin
                low_count_d = low_count_q - tlpca_pkg::COUNT_W'(1);
              end else begin
                high_count_d = high_count_q - tlpca_pkg::COUNT_W'(1);
              end
            end else begin
              core_busy_d[rel_core] = 1'b0;
            end
          end
        end
        tlpca_pkg::OP_CANCEL: begin
          cmd.drop_en = 1'b1;
          cmd.sel     = tlpca_pkg::SEL_TICKET;
          if (chain_end.found) begin
            status_d = tlpca_pkg::ST_CANCELLED;
            ticket_in_use_d[chain_end.pick_ticket] = 1'b0;
            if (chain_end.pick_low) begin
              low_count_d = low_count_q - tlpca_pkg::COUNT_W'(1);
            end else begin
              high_count_d = high_count_q - tlpca_pkg::COUNT_W'(1);
            end
          end
        end
        default: begin
          // unused opcode changes nothing and reports bad ticket
          status_d = tlpca_pkg::ST_BAD_TICKET;
        end
      endcase
    end
  end

  // control, configuration and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      done_q          <= 1'b0;
      cores_in_use_q  <= tlpca_pkg::CFG_CORES_W'(2);
      hw_error_q      <= 1'b0;
      core_busy_q     <= '0;
      ticket_in_use_q <= '0;
      high_count_q    <= '0;
      low_count_q     <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tlpca_pkg::REG_CORES_IN_USE: cores_in_use_q <= cfg_data_i;
          tlpca_pkg::REG_HW_ERROR:     hw_error_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      core_busy_q     <= core_busy_d;
      ticket_in_use_q <= ticket_in_use_d;
      high_count_q    <= high_count_d;
      low_count_q     <= low_count_d;
    end
  end

  // command latch and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= opcode_i;
      prio_q    <= priority_req_i;
      core_q    <= core_index_i;
      cticket_q <= cancel_ticket_i;
    end
    if (busy_q) begin
      status_q <= status_d;
      gcore_q  <= gcore_d;
      ticket_q <= ticket_d;
      hv_q     <= hv_d;
      ht_q     <= ht_d;
      hc_q     <= hc_d;
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_core_o   = gcore_q;
  assign ticket_o         = ticket_q;
  assign handoff_valid_o  = hv_q;
  assign handoff_ticket_o = ht_q;
  assign handoff_core_o   = hc_q;
  // state registers already hold the after-step values while done_o is high
  assign busy_mask_o      = core_busy_q;
  assign high_waiting_o   = high_count_q;
  assign low_waiting_o    = low_count_q;

endmodule

// ----- design/tlpca_checker.sv -----
// port-level checks of the allocator, bound to the top level
`include "two_level_priority_core_allocator_macros.svh"

module tlpca_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [tlpca_pkg::OPCODE_W-1:0]    opcode_i,
  input logic [tlpca_pkg::PRIO_W-1:0]      priority_req_i,
  input logic [tlpca_pkg::CORE_IDX_W-1:0]  core_index_i,
  input logic [tlpca_pkg::TICKET_W-1:0]    cancel_ticket_i,
  input logic                              done_o,
  input logic [tlpca_pkg::STATUS_W-1:0]    status_o,
  input logic [tlpca_pkg::CORE_W-1:0]      granted_core_o,
  input logic [tlpca_pkg::TICKET_W-1:0]    ticket_o,
  input logic                              handoff_valid_o,
  input logic [tlpca_pkg::TICKET_W-1:0]    handoff_ticket_o,
  input logic [tlpca_pkg::CORE_W-1:0]      handoff_core_o,
  input logic [tlpca_pkg::CORES-1:0]       busy_mask_o,
  input logic [tlpca_pkg::COUNT_W-1:0]     high_waiting_o,
  input logic [tlpca_pkg::COUNT_W-1:0]     low_waiting_o,
  input logic                              cfg_we_i,
  input logic                              cfg_index_i,
  input logic [tlpca_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // every accepted item yields a result after its busy cycle
  `TLPCA_CHECK(a_result_follows, start && !busy |=> ##1 done_o)
  `TLPCA_CHECK(a_no_spurious_result, done_o |-> $past(busy))
  // only a release can hand a core to a waiter
  `TLPCA_CHECK(a_handoff_on_release, done_o && handoff_valid_o |-> status_o == tlpca_pkg::ST_RELEASED)
  // a granted or handed-over core is reserved afterwards
  `TLPCA_CHECK(a_grant_marks_busy, done_o && status_o == tlpca_pkg::ST_GRANTED |-> busy_mask_o[granted_core_o])
  `TLPCA_CHECK(a_handoff_keeps_busy, done_o && handoff_valid_o |-> busy_mask_o[handoff_core_o])

endmodule

bind two_level_priority_core_allocator tlpca_checker u_tlpca_checker (.*);

// ----- test/tb_two_level_priority_core_allocator.sv -----
// self-checking testbench of the two-level priority core allocator
module tb_two_level_priority_core_allocator;
  import tlpca_pkg::*;

  // opcode and priority values the package leaves unnamed
  localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
  localparam logic [PRIO_W-1:0]   PRIO_BAD_A = 2'd2;
  localparam logic [PRIO_W-1:0]   PRIO_BAD_B = 2'd3;

  // generous ceiling on the whole run, in clock cycles
  localparam int RUN_LIMIT = 100000;
  // cycles between the last result and a register write
  localparam int SETTLE_CYCLES = 4;

  // one result item, field by field at port widths
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CORE_W-1:0]   gcore;
    logic [TICKET_W-1:0] tk;
    logic                hv;
    logic [TICKET_W-1:0] ht;
    logic [CORE_W-1:0]   hc;
    logic [CORES-1:0]    bmask;
    logic [COUNT_W-1:0]  hcnt;
    logic [COUNT_W-1:0]  lcnt;
  } alloc_res_t;

  // one line of the directed script: a register write or an item
  typedef struct {
    bit                   is_cfg;
    logic                 cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic [OPCODE_W-1:0]  op;
    logic [PRIO_W-1:0]    prio;
    logic [CORE_IDX_W-1:0] core;
    logic [TICKET_W-1:0]  ct;
    bit                   pinned;
    alloc_res_t           res;
  } script_row_t;

  // request mix of a random phase
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OPCODE_W-1:0]   opcode_i = '0;
  logic [PRIO_W-1:0]     priority_req_i = '0;
  logic [CORE_IDX_W-1:0] core_index_i = '0;
  logic [TICKET_W-1:0]   cancel_ticket_i = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [CORE_W-1:0]     granted_core_o;
  logic [TICKET_W-1:0]   ticket_o;
  logic                  handoff_valid_o;
  logic [TICKET_W-1:0]   handoff_ticket_o;
  logic [CORE_W-1:0]     handoff_core_o;
  logic [CORES-1:0]      busy_mask_o;
  logic [COUNT_W-1:0]    high_waiting_o;
  logic [COUNT_W-1:0]    low_waiting_o;
  logic                  cfg_we_i = 1'b0;
  logic                  cfg_index_i = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // typed-in expectation that travels with the driven item
  bit         pin_q = 1'b0;
  alloc_res_t pin_res_q = '0;

  two_level_priority_core_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .opcode_i         (opcode_i),
    .priority_req_i   (priority_req_i),
    .core_index_i     (core_index_i),
    .cancel_ticket_i  (cancel_ticket_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_core_o   (granted_core_o),
    .ticket_o         (ticket_o),
    .handoff_valid_o  (handoff_valid_o),
    .handoff_ticket_o (handoff_ticket_o),
    .handoff_core_o   (handoff_core_o),
    .busy_mask_o      (busy_mask_o),
    .high_waiting_o   (high_waiting_o),
    .low_waiting_o    (low_waiting_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // allocator state as the testbench sees it
  // ---------------------------------------------------------------------
  logic [CFG_CORES_W-1:0] m_cores = 2'd2;
  logic                   m_hw = 1'b0;
  logic [CORES-1:0]       m_busy = '0;
  bit                     m_tkt_used [POOL];
  entry_t                 wait_q [POOL];
  logic [COUNT_W-1:0]     m_hcnt = '0;
  logic [COUNT_W-1:0]     m_lcnt = '0;

  alloc_res_t pending_results [$];
  int         mism_cnt = 0;
  int         cycle_cnt = 0;
  bit         gaps_on = 1'b1;

  initial begin
    for (int i = 0; i < POOL; i++) begin
      m_tkt_used[i] = 1'b0;
      wait_q[i] = '0;
    end
  end

  // cores_in_use above the core count behaves as the core count
  function automatic int usable_cores();
    return (int'(m_cores) > CORES) ? CORES : int'(m_cores);
  endfunction

  // oldest waiter of the given class, -1 if none
  function automatic int oldest_waiter(bit want_low);
    for (int i = 0; i < POOL; i++)
      if (wait_q[i].valid && wait_q[i].is_low == want_low) return i;
    return -1;
  endfunction

  // waiter leaves the queue: ticket back to the pool, queue closes the hole
  function automatic void remove_waiter(int pos);
    m_tkt_used[wait_q[pos].ticket] = 1'b0;
    if (wait_q[pos].is_low) m_lcnt--;
    else m_hcnt--;
    for (int i = pos; i < POOL - 1; i++) wait_q[i] = wait_q[i + 1];
    wait_q[POOL - 1] = '0;
  endfunction

  // next result of the allocator for one command, state updated in place
  function automatic alloc_res_t predict_alloc(logic [OPCODE_W-1:0] op,
                                               logic [PRIO_W-1:0] prio,
                                               logic [CORE_IDX_W-1:0] core,
                                               logic [TICKET_W-1:0] ct);
    alloc_res_t r;
    int n;
    int w;
    int pos;
    bit got_core;
    r = '0;
    r.status = ST_BAD_TICKET;
    n = usable_cores();
    got_core = 1'b0;
    case (op)
      OP_RESERVE: begin
        if (m_hw) begin
          r.status = ST_HW_ERROR;
        end else if (prio != PRIO_HIGH && prio != PRIO_LOW) begin
          r.status = ST_BAD_PRIORITY;
        end else begin
          // lowest idle core among the usable ones
          for (int i = 0; i < n; i++) begin
            if (!m_busy[i]) begin
              m_busy[i] = 1'b1;
              r.gcore = CORE_W'(i);
              r.status = ST_GRANTED;
              got_core = 1'b1;
              break;
            end
          end
          // otherwise lowest free ticket, appended behind every waiter
          if (!got_core) begin
            r.status = ST_POOL_FULL;
            pos = int'(m_hcnt) + int'(m_lcnt);
            for (int i = 0; i < POOL; i++) begin
              if (!m_tkt_used[i]) begin
                m_tkt_used[i] = 1'b1;
                wait_q[pos].valid = 1'b1;
                wait_q[pos].is_low = (prio == PRIO_LOW);
                wait_q[pos].ticket = TICKET_W'(i);
                if (prio == PRIO_LOW) m_lcnt++;
                else m_hcnt++;
                r.tk = TICKET_W'(i);
                r.status = ST_QUEUED;
                break;
              end
            end
          end
        end
      end
      OP_RELEASE: begin
        if (int'(core) >= n) begin
          r.status = ST_BAD_CORE;
        end else if (!m_busy[core]) begin
          r.status = ST_ALREADY_FREE;
        end else begin
          r.status = ST_RELEASED;
          w = oldest_waiter(1'b0);
          if (w < 0) w = oldest_waiter(1'b1);
          if (w >= 0) begin
            // core goes straight on to the waiter and stays reserved
            r.hv = 1'b1;
            r.ht = wait_q[w].ticket;
            r.hc = CORE_W'(core);
            remove_waiter(w);
          end else begin
            m_busy[core] = 1'b0;
          end
        end
      end
      OP_CANCEL: begin
        for (int i = 0; i < POOL; i++) begin
          if (wait_q[i].valid && wait_q[i].ticket == ct) begin
            remove_waiter(i);
            r.status = ST_CANCELLED;
            break;
          end
        end
      end
      default: ;
    endcase
    r.bmask = m_busy;
    r.hcnt = m_hcnt;
    r.lcnt = m_lcnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // item acceptance, prediction and result checking, all on the rising edge
  // ---------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mism_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    alloc_res_t nxt;
    alloc_res_t want;
    if (rst_ni) begin
      // accepted item: predictor always runs to keep its state in step
      if (start && !busy) begin
        nxt = predict_alloc(opcode_i, priority_req_i, core_index_i, cancel_ticket_i);
        if (pin_q) nxt = pin_res_q;
        pending_results.push_back(nxt);
      end
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d", $time, status_o);
          mism_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status_o);
          check_field("granted_core", want.gcore, granted_core_o);
          check_field("ticket", want.tk, ticket_o);
          check_field("handoff_valid", want.hv, handoff_valid_o);
          check_field("handoff_ticket", want.ht, handoff_ticket_o);
          check_field("handoff_core", want.hc, handoff_core_o);
          check_field("busy_mask", want.bmask, busy_mask_o);
          check_field("high_waiting", want.hcnt, high_waiting_o);
          check_field("low_waiting", want.lcnt, low_waiting_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("tb_two_level_priority_core_allocator failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // one item: optional idle burst, then hold start until the accept edge
  task automatic send_item(logic [OPCODE_W-1:0] op, logic [PRIO_W-1:0] prio,
                           logic [CORE_IDX_W-1:0] core, logic [TICKET_W-1:0] ct,
                           bit pin, alloc_res_t pres);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    priority_req_i <= prio;
    core_index_i <= core;
    cancel_ticket_i <= ct;
    pin_q <= pin;
    pin_res_q <= pres;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending until every expected result is in, then let the block settle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CORES_IN_USE) m_cores = val;
    else m_hw = val[0];
  endtask

  function automatic alloc_res_t mk_res(logic [STATUS_W-1:0] st, int g, int tk, int hv,
                                        int ht, int hc, int bm, int hn, int ln);
    alloc_res_t r;
    r.status = st;
    r.gcore = CORE_W'(g);
    r.tk = TICKET_W'(tk);
    r.hv = 1'(hv);
    r.ht = TICKET_W'(ht);
    r.hc = CORE_W'(hc);
    r.bmask = CORES'(bm);
    r.hcnt = COUNT_W'(hn);
    r.lcnt = COUNT_W'(ln);
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic idx, logic [CFG_DATA_W-1:0] val);
    script_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  // pin set: the typed-in result replaces the predicted one
  function automatic script_row_t item_row(logic [OPCODE_W-1:0] op, logic [PRIO_W-1:0] prio,
                                           logic [CORE_IDX_W-1:0] core,
                                           logic [TICKET_W-1:0] ct, bit pin,
                                           alloc_res_t res);
    script_row_t s;
    s = '{default: '0};
    s.op = op;
    s.prio = prio;
    s.core = core;
    s.ct = ct;
    s.pinned = pin;
    s.res = res;
    return s;
  endfunction

  // random item biased by phase mix, mostly aimed at live cores and tickets
  task automatic pick_item(mix_e mix, output logic [OPCODE_W-1:0] op,
                           output logic [PRIO_W-1:0] prio,
                           output logic [CORE_IDX_W-1:0] core,
                           output logic [TICKET_W-1:0] ct);
    int r;
    int res_pct;
    int rel_pct;
    int n;
    int waiting;
    r = $urandom_range(0, 99);
    op = OPCODE_W'($urandom_range(0, 3));
    prio = PRIO_W'($urandom_range(0, 3));
    core = CORE_IDX_W'($urandom_range(0, 3));
    ct = TICKET_W'($urandom_range(0, POOL - 1));
    // a small share of fully random noise, opcode 3 included
    if (r < 8) return;
    case (mix)
      MIX_FILL: begin res_pct = 70; rel_pct = 20; end
      MIX_DRAIN: begin res_pct = 20; rel_pct = 50; end
      default: begin res_pct = 45; rel_pct = 35; end
    endcase
    r = $urandom_range(0, 99);
    n = usable_cores();
    waiting = int'(m_hcnt) + int'(m_lcnt);
    if (r < res_pct) begin
      op = OP_RESERVE;
      if ($urandom_range(0, 19) != 0) prio = PRIO_W'($urandom_range(0, 1));
    end else if (r < res_pct + rel_pct) begin
      op = OP_RELEASE;
      if (n > 0 && $urandom_range(0, 99) < 85) core = CORE_IDX_W'($urandom_range(0, n - 1));
    end else begin
      op = OP_CANCEL;
      if (waiting > 0 && $urandom_range(0, 99) < 85)
        ct = wait_q[$urandom_range(0, waiting - 1)].ticket;
    end
  endtask

  // one random phase under a fixed register setting
  task automatic run_phase(logic [CFG_DATA_W-1:0] cores, logic hw, mix_e mix,
                           int count, bit gaps);
    logic [OPCODE_W-1:0] op;
    logic [PRIO_W-1:0] prio;
    logic [CORE_IDX_W-1:0] core;
    logic [TICKET_W-1:0] ct;
    write_reg(REG_CORES_IN_USE, cores);
    // upper data bit is ignored by the flag, toggle it anyway
    write_reg(REG_HW_ERROR, {1'($urandom_range(0, 1)), hw});
    gaps_on = gaps;
    for (int i = 0; i < count; i++) begin
      pick_item(mix, op, prio, core, ct);
      send_item(op, prio, core, ct, 1'b0, '0);
    end
  endtask

  script_row_t script [$];

  initial begin
    // directed script: reset defaults are two usable cores, no hw error
    script.push_back(item_row(OP_RESERVE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_GRANTED, 0, 0, 0, 0, 0, 1, 0, 0)));
    script.push_back(item_row(OP_RESERVE, PRIO_LOW, 0, 0, 1,
                              mk_res(ST_GRANTED, 1, 0, 0, 0, 0, 3, 0, 0)));
    script.push_back(item_row(OP_RESERVE, PRIO_LOW, 0, 0, 1,
                              mk_res(ST_QUEUED, 0, 0, 0, 0, 0, 3, 0, 1)));
    script.push_back(item_row(OP_RESERVE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_QUEUED, 0, 1, 0, 0, 0, 3, 1, 1)));
    script.push_back(item_row(OP_RESERVE, PRIO_BAD_A, 0, 0, 1,
                              mk_res(ST_BAD_PRIORITY, 0, 0, 0, 0, 0, 3, 1, 1)));
    script.push_back(item_row(OP_RESERVE, PRIO_BAD_B, 0, 0, 1,
                              mk_res(ST_BAD_PRIORITY, 0, 0, 0, 0, 0, 3, 1, 1)));
    // high waiter wins over the older low waiter
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 1, 0, 1,
                              mk_res(ST_RELEASED, 0, 0, 1, 1, 1, 3, 0, 1)));
    // a handed-over ticket can no longer be cancelled
    script.push_back(item_row(OP_CANCEL, PRIO_HIGH, 0, 1, 1,
                              mk_res(ST_BAD_TICKET, 0, 0, 0, 0, 0, 3, 0, 1)));
    script.push_back(item_row(OP_CANCEL, PRIO_HIGH, 0, 15, 1,
                              mk_res(ST_BAD_TICKET, 0, 0, 0, 0, 0, 3, 0, 1)));
    // unused opcode aimed at a live ticket changes nothing
    script.push_back(item_row(OP_UNUSED, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_BAD_TICKET, 0, 0, 0, 0, 0, 3, 0, 1)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 2, 0, 1,
                              mk_res(ST_BAD_CORE, 0, 0, 0, 0, 0, 3, 0, 1)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 3, 0, 1,
                              mk_res(ST_BAD_CORE, 0, 0, 0, 0, 0, 3, 0, 1)));
    script.push_back(item_row(OP_CANCEL, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_CANCELLED, 0, 0, 0, 0, 0, 3, 0, 0)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_RELEASED, 0, 0, 0, 0, 0, 2, 0, 0)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_ALREADY_FREE, 0, 0, 0, 0, 0, 2, 0, 0)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 1, 0, 1,
                              mk_res(ST_RELEASED, 0, 0, 0, 0, 0, 0, 0, 0)));
    // hw error is checked before the priority
    script.push_back(cfg_row(REG_HW_ERROR, 2'd1));
    script.push_back(item_row(OP_RESERVE, PRIO_BAD_B, 0, 0, 1,
                              mk_res(ST_HW_ERROR, 0, 0, 0, 0, 0, 0, 0, 0)));
    script.push_back(item_row(OP_RESERVE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_HW_ERROR, 0, 0, 0, 0, 0, 0, 0, 0)));
    // no usable cores: reserves queue, every release is a bad core
    script.push_back(cfg_row(REG_HW_ERROR, 2'd0));
    script.push_back(cfg_row(REG_CORES_IN_USE, 2'd0));
    script.push_back(item_row(OP_RESERVE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_QUEUED, 0, 0, 0, 0, 0, 0, 1, 0)));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 0, 0, 1,
                              mk_res(ST_BAD_CORE, 0, 0, 0, 0, 0, 0, 1, 0)));
    // three cores asked for, two exist
    script.push_back(cfg_row(REG_CORES_IN_USE, 2'd3));
    script.push_back(item_row(OP_RESERVE, PRIO_LOW, 0, 0, 0, '0));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 0, 0, 0, '0));
    script.push_back(item_row(OP_RESERVE, PRIO_LOW, 0, 0, 0, '0));
    // shrink under a busy core: it is out of reach until widened again
    script.push_back(cfg_row(REG_CORES_IN_USE, 2'd1));
    script.push_back(item_row(OP_RELEASE, PRIO_HIGH, 1, 0, 0, '0));
    script.push_back(item_row(OP_RESERVE, PRIO_HIGH, 0, 0, 0, '0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].cfg_idx, script[i].cfg_val);
      else send_item(script[i].op, script[i].prio, script[i].core, script[i].ct,
                     script[i].pinned, script[i].res);
    end

    // random phases; each starts from idle, which also exercises a full
    // pause of the sender until every result is back
    run_phase(2'd2, 1'b0, MIX_FILL,     70,  1);
    run_phase(2'd2, 1'b0, MIX_DRAIN,    60,  1);
    run_phase(2'd1, 1'b0, MIX_FILL,     70,  1);
    run_phase(2'd0, 1'b0, MIX_FILL,     45,  1);
    run_phase(2'd3, 1'b0, MIX_DRAIN,    60,  1);
    run_phase(2'd2, 1'b1, MIX_BALANCED, 30,  1);
    run_phase(2'd2, 1'b0, MIX_BALANCED, 100, 1);
    run_phase(2'd1, 1'b0, MIX_DRAIN,    60,  1);
    // closing stretch back to back, no idle cycles
    run_phase(2'd3, 1'b0, MIX_BALANCED, 60,  0);
    run_phase(2'd2, 1'b0, MIX_FILL,     70,  0);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mism_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_two_level_priority_core_allocator passed");
    end else begin
      $display("tb_two_level_priority_core_allocator failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tlpca_pkg.sv
design/tlpca_cell.sv
design/two_level_priority_core_allocator.sv
design/tlpca_checker.sv
test/tb_two_level_priority_core_allocator.sv
